@@ hdl/srla_pkg.sv @@
// Shared types, codes and default sizes for the sorted rating list average unit.
`default_nettype none

package srla_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int RATING_WIDTH_DEF = 8;

    localparam logic [0:0] FUNC_INSERT = 1'b0;
    localparam logic [0:0] FUNC_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [0:0] func;
        logic [7:0] rating;
    } srla_req_t;

    typedef struct packed {
        logic [7:0]  removed_rating;
        logic [1:0]  status;
        logic [4:0]  entry_count;
        logic [15:0] mean_q8;
    } srla_result_t;

endpackage

`default_nettype wire

@@ hdl/srla_cell.sv @@
// One slot of the ordered rating chain, shifting up past smaller new ratings.
`default_nettype none

module srla_cell #(
    parameter int RW  = srla_pkg::RATING_WIDTH_DEF,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  wire logic          clk,
    input  wire logic          ins_en,
    input  wire logic [CW-1:0] count,
    input  wire logic [RW-1:0] rating,
    input  wire logic          below_gt,
    input  wire logic [RW-1:0] below_value,
    output logic               gt,
    output logic [RW-1:0]      value
);

    localparam logic [CW-1:0] POS = CW'(IDX);

    logic [RW-1:0] value_reg;
    logic [RW-1:0] value_next;
    logic          occupied;
    logic          at_top;

    assign occupied = (POS < count);
    assign at_top   = (POS == count);
    assign gt       = occupied && (value_reg > rating);
    assign value    = value_reg;

    // A larger rating below moves up into this slot; otherwise the slot that
    // sits just above all ratings not larger than the new one takes it.
    always_comb
    begin
        value_next = value_reg;
        if (ins_en)
        begin
            if (below_gt)
            begin
                value_next = below_value;
            end
            else if (gt || at_top)
            begin
                value_next = rating;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

@@ hdl/srla_divider.sv @@
// Restoring divider producing one quotient bit per cycle.
`default_nettype none

module srla_divider #(
    parameter int CW = 5,
    parameter int QW = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic [CW-1:0]    rem_init,
    input  wire logic [QW-1:0]    dividend_low,
    input  wire logic [CW-1:0]    divisor,
    output logic [QW-1:0]         quotient,
    output logic                  finish
);

    localparam int NW = $clog2(QW + 1);

    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic [QW-1:0] work_reg;
    logic [QW-1:0] work_next;
    logic [CW-1:0] div_reg;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] cnt_next;
    logic          finish_reg;
    logic          finish_next;
    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, work_reg[QW-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    // The remainder stays below the divisor, so the difference fits CW bits.
    always_comb
    begin
        rem_next    = rem_reg;
        work_next   = work_reg;
        cnt_next    = cnt_reg;
        finish_next = 1'b0;
        if (load)
        begin
            rem_next  = rem_init;
            work_next = dividend_low;
            cnt_next  = NW'(QW);
        end
        else if (cnt_reg != '0)
        begin
            rem_next    = fits ? diff[CW-1:0] : trial[CW-1:0];
            work_next   = {work_reg[QW-2:0], fits};
            cnt_next    = cnt_reg - NW'(1);
            finish_next = (cnt_reg == NW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            finish_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            finish_reg <= finish_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        if (load)
        begin
            div_reg <= divisor;
        end
    end

    assign quotient = work_reg;
    assign finish   = finish_reg;

endmodule

`default_nettype wire

@@ hdl/sorted_rating_list_average_unit.sv @@
// Top level of the sorted rating list average unit.
// The bit-serial mean divider works through each accepted request; busy stays high
// until the result is ready and is low again in the cycle the result is shown, so
// no new request is taken before the last one is done. The receiver cannot stall
// the result.
// Reset clears the count, the total and the control state; stored ratings are not cleared.
`default_nettype none

module sorted_rating_list_average_unit #(
    parameter int CAPACITY     = srla_pkg::CAPACITY_DEF,
    parameter int RATING_WIDTH = srla_pkg::RATING_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire srla_pkg::srla_req_t   req,
    output logic                       done,
    output srla_pkg::srla_result_t     result
);

    // Count holds 0 to CAPACITY; the total holds CAPACITY ratings at full scale.
    localparam int RW = RATING_WIDTH;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int TW = RW + CW;
    // The mean never exceeds the largest rating, so RW + 8 quotient bits suffice.
    localparam int QW = RW + 8;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [TW-1:0] total_reg;
    logic [TW-1:0] total_next;

    logic [7:0]  removed_reg;
    logic [7:0]  removed_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [4:0]  entry_reg;
    logic [4:0]  entry_next;
    logic        empty_reg;

    srla_pkg::srla_result_t result_reg;
    logic                   done_reg;

    logic          accept;
    logic          ins_en;
    logic [RW-1:0] rating_in;
    logic [RW+7:0] rating_wide;

    logic [RW-1:0] cell_value [CAPACITY];
    logic          cell_gt    [CAPACITY];

    logic [CW-1:0] top_pos;
    logic [IW-1:0] top_idx;
    logic [RW-1:0] top_value;
    logic [RW+7:0] top_wide;
    logic [CW+4:0] count_wide;

    logic [TW+7:0] dividend;
    logic [QW-1:0] quotient;
    logic          div_finish;
    logic [QW+15:0] quot_wide;
    logic [15:0]   mean_val;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // The incoming rating keeps only its low RATING_WIDTH bits.
    assign rating_wide = {{RW{1'b0}}, req.rating};
    assign rating_in   = rating_wide[RW-1:0];

    // The largest held rating sits in the slot just below the count.
    assign top_pos   = count_reg - CW'(1);
    assign top_idx   = top_pos[IW-1:0];
    assign top_value = cell_value[top_idx];
    assign top_wide  = {8'b0, top_value};

    // Decide the request against the current count and total.
    always_comb
    begin
        ins_en       = 1'b0;
        count_next   = count_reg;
        total_next   = total_reg;
        removed_next = 8'b0;
        status_next  = srla_pkg::STATUS_DONE;
        if (req.func == srla_pkg::FUNC_INSERT)
        begin
            if (count_reg >= CW'(CAPACITY))
            begin
                status_next = srla_pkg::STATUS_FULL;
            end
            else
            begin
                ins_en     = accept;
                count_next = count_reg + CW'(1);
                total_next = total_reg + {{CW{1'b0}}, rating_in};
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                status_next = srla_pkg::STATUS_EMPTY;
            end
            else
            begin
                count_next   = top_pos;
                total_next   = total_reg - {{CW{1'b0}}, top_value};
                removed_next = top_wide[7:0];
            end
        end
    end

    assign count_wide = {5'b0, count_next};
    assign entry_next = count_wide[4:0];

    // The chain of slots, each looking only at its lower neighbor.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic          below_gt;
            logic [RW-1:0] below_value;
            if (gi == 0)
            begin : g_first
                assign below_gt    = 1'b0;
                assign below_value = '0;
            end
            else
            begin : g_rest
                assign below_gt    = cell_gt[gi-1];
                assign below_value = cell_value[gi-1];
            end
            srla_cell #(
                .RW  (RW),
                .CW  (CW),
                .IDX (gi)
            ) u_cell (
                .clk         (clk),
                .ins_en      (ins_en),
                .count       (count_reg),
                .rating      (rating_in),
                .below_gt    (below_gt),
                .below_value (below_value),
                .gt          (cell_gt[gi]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    // Mean is total * 256 / count. The top CW dividend bits are already below
    // the count, so they seed the remainder and only QW bits are iterated.
    assign dividend = {total_next, 8'b0};

    srla_divider #(
        .CW (CW),
        .QW (QW)
    ) u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .rem_init     (dividend[TW+7:QW]),
        .dividend_low (dividend[QW-1:0]),
        .divisor      (count_next),
        .quotient     (quotient),
        .finish       (div_finish)
    );

    // Wide ratings can push the mean past 16 bits; it saturates there.
    assign quot_wide = {16'b0, quotient};
    assign mean_val  = empty_reg ? 16'b0 :
                       ((quot_wide[QW+15:16] != '0) ? 16'hFFFF : quot_wide[15:0]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DIV) && div_finish;
            if (accept)
            begin
                count_reg <= count_next;
                total_reg <= total_next;
            end
        end
    end

    // Per-request fields wait here while the divider works.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg <= removed_next;
            status_reg  <= status_next;
            entry_reg   <= entry_next;
            empty_reg   <= (count_next == '0);
        end
        if ((state_reg == S_DIV) && div_finish)
        begin
            result_reg.removed_rating <= removed_reg;
            result_reg.status         <= status_reg;
            result_reg.entry_count    <= entry_reg;
            result_reg.mean_q8        <= mean_val;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
